// ===== hdl/psiet_pkg.sv =====
// Types and constants shared by the per-source ICMP error tally block.
package psiet_pkg;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] src_addr;
    logic        port_valid;
    logic [15:0] udp_port;
  } psiet_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  entry_index;
    logic [31:0] weight_total;
    logic [31:0] tcp_count;
    logic [31:0] udp_sent_count;
    logic [31:0] ping_count;
    logic [31:0] unreach_count;
    logic [31:0] redirect_count;
    logic [31:0] ttl_count;
    logic [31:0] udp_recv_count;
    logic [3:0]  distinct_ports;
  } psiet_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MUL, ST_FOLD, ST_MOD, ST_LOOK, ST_KEY,
    ST_CTR, ST_PSCAN, ST_PCMP, ST_DONE
  } psiet_state_t;

  localparam logic [2:0] KIND_TCP     = 3'd0;
  localparam logic [2:0] KIND_USENT   = 3'd1;
  localparam logic [2:0] KIND_PING    = 3'd2;
  localparam logic [2:0] KIND_UNREACH = 3'd3;
  localparam logic [2:0] KIND_REDIR   = 3'd4;
  localparam logic [2:0] KIND_TTL     = 3'd5;
  localparam logic [2:0] KIND_URECV   = 3'd6;

  localparam logic [1:0] STAT_UPDATED = 2'd0;
  localparam logic [1:0] STAT_CREATED = 2'd1;
  localparam logic [1:0] STAT_DROPPED = 2'd2;

  localparam int NUM_CTR    = 8;
  localparam int CT_WEIGHT  = 0;
  localparam int CT_TCP     = 1;
  localparam int CT_USENT   = 2;
  localparam int CT_PING    = 3;
  localparam int CT_UNREACH = 4;
  localparam int CT_REDIR   = 5;
  localparam int CT_TTL     = 6;
  localparam int CT_URECV   = 7;

  localparam logic [31:0] HASH_MULT = 32'h045D9F3B;
  localparam logic [3:0]  UNREACH_WEIGHT_RST = 4'd2;

endpackage

// ===== hdl/per_source_icmp_error_tally_top.sv =====
// Per-source ICMP error tally: hashed per-source counter table, top level.
//
// Each item is one traffic event for an IPv4 source. The address is hashed
// to a bucket of WAYS entries; a matching valid entry has the counter for the
// event kind bumped, otherwise the lowest free way takes a new entry, and a
// full bucket drops the event (status 2, all other fields zero). One result
// item leaves for every input item. State lives in three RAMs: a key RAM
// holding one bucket (valid bit and key per way) per row, a counter RAM with
// the eight 32-bit counters and the used-slot count per entry, and a port RAM
// with one port number and tally per slot. Items are handled one at a time;
// each goes through accept, multiply, fold, bucket read, counter read and
// write back, a dropped event skips the counter update and write back, and
// when BUCKETS is not a power of two the bucket is a reciprocal-multiply
// remainder of the hash (multiply, multiply back, subtract and correct).
// A UDP-sent event with a port also scans the port slots in turn, since the
// port RAM gives one slot per read. A stalled result holds the block in its
// final state until the result register frees. After reset the key RAM is
// cleared one bucket per cycle, and no item is taken until that pass ends;
// write configuration only while the block idles.
module per_source_icmp_error_tally_top #(
  parameter int BUCKETS    = 256,
  parameter int WAYS       = 4,
  parameter int PORT_SLOTS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [3:0]           cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  psiet_pkg::psiet_req_t in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output psiet_pkg::psiet_rsp_t out_data
);
  import psiet_pkg::*;

  localparam int ENTRIES = BUCKETS * WAYS;
  localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PAW = (ENTRIES * PORT_SLOTS > 1) ? $clog2(ENTRIES * PORT_SLOTS) : 1;
  localparam int SW1 = $clog2(PORT_SLOTS + 1);
  localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam int KROW = WAYS * 33;
  localparam int CW   = NUM_CTR * 32 + SW1;
  // reciprocal of the bucket count, scaled by 2^(32 + floor(log2 BUCKETS))
  localparam int FL   = $clog2(BUCKETS + 1) - 1;
  localparam logic [63:0] RECIP = (64'd1 << (32 + FL)) / 64'(BUCKETS);

  psiet_state_t state, state_next;

  // item and working registers
  psiet_req_t             req;
  logic [3:0]             unreach_weight;
  logic [31:0]            prod;
  logic [31:0]            hx;
  logic [1:0]             mod_step;
  logic [31:0]            quot;
  logic [31:0]            qb;
  logic [BW-1:0]          bucket;
  logic [BW-1:0]          clr_cnt;
  logic [EW-1:0]          e;
  logic [1:0]             status;
  logic [NUM_CTR-1:0][31:0] cnt;
  logic [SW1-1:0]         pu;
  logic [SW1-1:0]         slot;
  logic [10:0]            entries_held;

  // RAM ports
  logic                   key_wr_en;
  logic [BW-1:0]          key_wr_addr;
  logic [WAYS-1:0][32:0]  key_wr_data;
  logic [WAYS-1:0][32:0]  key_rd_data;
  logic                   ctr_wr_en;
  logic [EW-1:0]          ctr_rd_addr;
  logic [CW-1:0]          ctr_rd_data;
  logic                   prt_wr_en;
  logic [PAW-1:0]         prt_addr;
  logic [47:0]            prt_wr_data;
  logic [47:0]            prt_rd_data;

  // lookup results
  logic                   hit;
  logic                   have_free;
  logic [WW-1:0]          hit_way;
  logic [WW-1:0]          free_way;
  logic [EW-1:0]          hit_e;
  logic [EW-1:0]          free_e;

  // counter update
  logic [NUM_CTR-1:0][31:0] ctr_upd;
  logic [31:0]            rem_diff;
  logic                   out_free;

  psiet_ram #(.WIDTH(KROW), .DEPTH(BUCKETS)) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (key_wr_addr),
    .wr_data (key_wr_data),
    .rd_addr (bucket),
    .rd_data (key_rd_data)
  );

  psiet_ram #(.WIDTH(CW), .DEPTH(ENTRIES)) u_ctr_ram (
    .clk     (clk),
    .wr_en   (ctr_wr_en),
    .wr_addr (e),
    .wr_data ({pu, cnt}),
    .rd_addr (ctr_rd_addr),
    .rd_data (ctr_rd_data)
  );

  psiet_ram #(.WIDTH(48), .DEPTH(ENTRIES * PORT_SLOTS)) u_port_ram (
    .clk     (clk),
    .wr_en   (prt_wr_en),
    .wr_addr (prt_addr),
    .wr_data (prt_wr_data),
    .rd_addr (prt_addr),
    .rd_data (prt_rd_data)
  );

  assign out_free = !out_valid || !out_stall;

  // Scan the bucket: lowest matching way, lowest free way.
  always_comb begin
    hit       = 1'b0;
    have_free = 1'b0;
    hit_way   = '0;
    free_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (key_rd_data[w][32]) begin
        if (!hit && key_rd_data[w][31:0] == req.src_addr) begin
          hit     = 1'b1;
          hit_way = WW'(w);
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_way  = WW'(w);
      end
    end
    hit_e  = EW'(bucket) * EW'(WAYS) + EW'(hit_way);
    free_e = EW'(bucket) * EW'(WAYS) + EW'(free_way);
  end

  // Hash less the estimated multiple of the bucket count; at most one bucket over.
  assign rem_diff = hx - qb;

  // Bump the kind's counter; new entries start at zero, non-TCP/USENT as ping.
  always_comb begin
    if (status == STAT_UPDATED) begin
      ctr_upd = ctr_rd_data[NUM_CTR*32-1:0];
      case (req.req_type)
        KIND_TCP:   ctr_upd[CT_TCP] = ctr_upd[CT_TCP] + 32'd1;
        KIND_USENT: ctr_upd[CT_USENT] = ctr_upd[CT_USENT] + 32'd1;
        KIND_PING: begin
          ctr_upd[CT_PING]   = ctr_upd[CT_PING] + 32'd1;
          ctr_upd[CT_WEIGHT] = ctr_upd[CT_WEIGHT] + 32'd1;
        end
        KIND_UNREACH: begin
          ctr_upd[CT_UNREACH] = ctr_upd[CT_UNREACH] + 32'd1;
          ctr_upd[CT_WEIGHT]  = ctr_upd[CT_WEIGHT] + 32'(unreach_weight);
        end
        KIND_REDIR: begin
          ctr_upd[CT_REDIR]  = ctr_upd[CT_REDIR] + 32'd1;
          ctr_upd[CT_WEIGHT] = ctr_upd[CT_WEIGHT] + 32'd1;
        end
        KIND_TTL: begin
          ctr_upd[CT_TTL]    = ctr_upd[CT_TTL] + 32'd1;
          ctr_upd[CT_WEIGHT] = ctr_upd[CT_WEIGHT] + 32'd1;
        end
        KIND_URECV: ctr_upd[CT_URECV] = ctr_upd[CT_URECV] + 32'd1;
        default: ;
      endcase
    end else begin
      ctr_upd = '0;
      if (req.req_type == KIND_TCP) begin
        ctr_upd[CT_TCP] = 32'd1;
      end else if (req.req_type == KIND_USENT) begin
        ctr_upd[CT_USENT] = 32'd1;
      end else begin
        ctr_upd[CT_PING]   = 32'd1;
        ctr_upd[CT_WEIGHT] = 32'd1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == BW'(BUCKETS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_MUL;
      ST_MUL:   state_next = ST_FOLD;
      ST_FOLD:  state_next = POW2 ? ST_LOOK : ST_MOD;
      ST_MOD:   if (mod_step == 2'd2) state_next = ST_LOOK;
      ST_LOOK:  state_next = ST_KEY;
      ST_KEY:   state_next = (hit || have_free) ? ST_CTR : ST_DONE;
      ST_CTR: begin
        if (req.req_type == KIND_USENT && req.port_valid) state_next = ST_PSCAN;
        else state_next = ST_DONE;
      end
      ST_PSCAN: state_next = (slot >= pu) ? ST_DONE : ST_PCMP;
      ST_PCMP: begin
        if (prt_rd_data[47:32] == req.udp_port || slot == SW1'(PORT_SLOTS - 1)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_PSCAN;
        end
      end
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Handshake and RAM controls.
  always_comb begin
    in_stall    = (state != ST_IDLE);
    key_wr_en   = 1'b0;
    key_wr_addr = bucket;
    key_wr_data = key_rd_data;
    ctr_wr_en   = 1'b0;
    ctr_rd_addr = (state == ST_KEY) ? hit_e : e;
    prt_wr_en   = 1'b0;
    prt_addr    = PAW'(e) * PAW'(PORT_SLOTS) + PAW'(slot);
    prt_wr_data = {req.udp_port, 32'd1};
    unique case (state)
      ST_CLEAR: begin
        key_wr_en   = 1'b1;
        key_wr_addr = clr_cnt;
        key_wr_data = '0;
      end
      ST_KEY: begin
        if (!hit && have_free) begin
          key_wr_en = 1'b1;
          key_wr_data[free_way] = {1'b1, req.src_addr};
        end
      end
      ST_PSCAN: prt_wr_en = (slot >= pu);
      ST_PCMP: begin
        prt_wr_en   = (prt_rd_data[47:32] == req.udp_port);
        prt_wr_data = {req.udp_port, prt_rd_data[31:0] + 32'd1};
      end
      ST_DONE: ctr_wr_en = out_free && (status != STAT_DROPPED);
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_cnt        <= '0;
      out_valid      <= 1'b0;
      unreach_weight <= UNREACH_WEIGHT_RST;
      entries_held   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + BW'(1);
      end
      if (cfg_wr_en) begin
        unreach_weight <= cfg_wr_data;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_KEY && !hit && have_free) begin
        entries_held <= entries_held + 11'd1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          req <= in_data;
        end
      end
      ST_MUL: prod <= (req.src_addr ^ (req.src_addr >> 16)) * HASH_MULT;
      ST_FOLD: begin
        hx       <= prod ^ (prod >> 16);
        bucket   <= (prod[BW-1:0] ^ prod[BW+15:16]) & BW'(BUCKETS - 1);
        mod_step <= 2'd0;
      end
      ST_MOD: begin
        mod_step <= mod_step + 2'd1;
        case (mod_step)
          2'd0: quot <= 32'((64'(hx) * 64'(RECIP[31:0])) >> (32 + FL));
          2'd1: qb <= quot * 32'(BUCKETS);
          default: begin
            bucket <= (rem_diff >= 32'(BUCKETS)) ? BW'(rem_diff - 32'(BUCKETS))
                                                 : BW'(rem_diff);
          end
        endcase
      end
      ST_KEY: begin
        if (hit) begin
          status <= STAT_UPDATED;
          e      <= hit_e;
        end else if (have_free) begin
          status <= STAT_CREATED;
          e      <= free_e;
        end else begin
          status <= STAT_DROPPED;
          e      <= '0;
          cnt    <= '0;
          pu     <= '0;
        end
      end
      ST_CTR: begin
        cnt  <= ctr_upd;
        pu   <= (status == STAT_UPDATED) ? ctr_rd_data[CW-1:NUM_CTR*32] : '0;
        slot <= '0;
      end
      ST_PSCAN: begin
        if (slot >= pu) begin
          pu <= slot + SW1'(1);
        end
      end
      ST_PCMP: slot <= slot + SW1'(1);
      ST_DONE: begin
        if (out_free) begin
          out_data.status         <= status;
          out_data.entry_index    <= 10'(e);
          out_data.weight_total   <= cnt[CT_WEIGHT];
          out_data.tcp_count      <= cnt[CT_TCP];
          out_data.udp_sent_count <= cnt[CT_USENT];
          out_data.ping_count     <= cnt[CT_PING];
          out_data.unreach_count  <= cnt[CT_UNREACH];
          out_data.redirect_count <= cnt[CT_REDIR];
          out_data.ttl_count      <= cnt[CT_TTL];
          out_data.udp_recv_count <= cnt[CT_URECV];
          out_data.distinct_ports <= 4'(pu);
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/psiet_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module psiet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
